// File: sv/arfc_pkg.sv
// Shared types and constants for the antialiased rectangle coverage fill.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package arfc_pkg;

    localparam int ARFC_COORD_INT_BITS = 16;
    localparam int ARFC_QUEUE_DEPTH    = 2;   // power of two
    localparam int ARFC_WORK_W         = 34;  // holds any edge difference at the widest setting
    localparam int ARFC_SLOTS          = 9;   // three rows of left, middle, right

    localparam logic [7:0] COV_FULL = 8'hFF;
    localparam logic [8:0] COV_ONE  = 9'd256;

    typedef logic signed [ARFC_WORK_W-1:0] work_t;

    typedef enum logic [1:0] {
        KIND_COLUMN = 2'd0,
        KIND_RUN    = 2'd1,
        KIND_RECT   = 2'd2
    } kind_t;

    // One classified rectangle. Slot bit 3*row+part, rows top/middle/bottom,
    // parts left/center/right.
    typedef struct packed {
        logic [ARFC_SLOTS-1:0] mask;
        logic                  single_col;
        logic [7:0]            frac_l;
        logic [7:0]            frac_r;
        logic [8:0]            wcol;
        logic [15:0]           x_left;
        logic [15:0]           x_left1;
        logic [15:0]           x_right;
        logic [15:0]           run_w;
        logic [15:0]           y_top;
        logic [15:0]           y_mid;
        logic [15:0]           y_bot;
        logic [15:0]           height;
        logic [7:0]            alpha_top;
        logic [7:0]            alpha_bot;
    } plan_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  cov;
        logic        last;
    } cmd_t;

endpackage

// File: sv/arfc_front.sv
// Front end: accepts a rectangle request and classifies it into a command plan.
// Depends on arfc_pkg.
module arfc_front #(
    parameter int COORD_INT_BITS = arfc_pkg::ARFC_COORD_INT_BITS
) (
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_INT_BITS+7:0]   left_edge,
    input  logic signed [COORD_INT_BITS+7:0]   top_edge,
    input  logic signed [COORD_INT_BITS+7:0]   right_edge,
    input  logic signed [COORD_INT_BITS+7:0]   bottom_edge,
    input  logic                               fill_interior,
    input  logic                               q_full,
    output logic                               push,
    output arfc_pkg::plan_t                    plan
);
    import arfc_pkg::*;

    work_t l_w, t_w, r_w, b_w;
    work_t l_fl, r_fl, rm1_fl, t_fl, b_fl, bm1_fl;
    work_t left1, top1, height, run_w, span_lr, span_tb;
    logic [7:0] frac_l, frac_r, frac_t, frac_b;
    logic       empty, single_col, single_row, run_ok, have_mid;
    logic [2:0] row_bits, mid_bits;

    always_comb begin
        l_w = work_t'(left_edge);
        t_w = work_t'(top_edge);
        r_w = work_t'(right_edge);
        b_w = work_t'(bottom_edge);

        frac_l = l_w[7:0];
        frac_r = r_w[7:0];
        frac_t = t_w[7:0];
        frac_b = b_w[7:0];

        l_fl   = l_w >>> 8;
        r_fl   = r_w >>> 8;
        rm1_fl = (r_w - work_t'(1)) >>> 8;
        t_fl   = t_w >>> 8;
        b_fl   = b_w >>> 8;
        bm1_fl = (b_w - work_t'(1)) >>> 8;

        empty      = (l_w >= r_w) || (t_w >= b_w);
        single_col = (l_fl == rm1_fl);
        single_row = (t_fl == bm1_fl);

        left1  = l_fl + work_t'(frac_l != 8'd0);
        top1   = t_fl + work_t'(frac_t != 8'd0);
        run_ok = (r_fl > left1);
        run_w  = r_fl - left1;
        height = b_fl - top1;
        have_mid = (height > work_t'(0));
        span_lr  = r_w - l_w;
        span_tb  = b_w - t_w - work_t'(1);

        row_bits = single_col ? 3'b001 : {frac_r != 8'd0, run_ok, frac_l != 8'd0};
        mid_bits = single_col ? 3'b001
                              : {frac_r != 8'd0, run_ok && fill_interior, frac_l != 8'd0};

        plan.single_col = single_col;
        plan.frac_l     = frac_l;
        plan.frac_r     = frac_r;
        plan.wcol       = span_lr[8:0];
        plan.x_left     = l_fl[15:0];
        plan.x_left1    = left1[15:0];
        plan.x_right    = r_fl[15:0];
        plan.run_w      = run_w[15:0];
        plan.y_top      = t_fl[15:0];
        plan.y_mid      = top1[15:0];
        plan.y_bot      = b_fl[15:0];
        plan.height     = height[15:0];
        plan.alpha_bot  = frac_b;

        if (single_row) begin
            plan.mask      = {6'b0, row_bits};
            plan.alpha_top = span_tb[7:0];
        end else begin
            plan.mask = {(frac_b != 8'd0) ? row_bits : 3'b000,
                         have_mid ? mid_bits : 3'b000,
                         (frac_t != 8'd0) ? row_bits : 3'b000};
            plan.alpha_top = 8'(COV_ONE - {1'b0, frac_t});
        end
    end

    // Drop empty rectangles and those that leave no command.
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full && !empty && (plan.mask != '0);

endmodule

// File: sv/arfc_queue.sv
// Short plan queue between the classifier and the command generator.
// Depends on arfc_pkg.
module arfc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  arfc_pkg::plan_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output arfc_pkg::plan_t head
);
    import arfc_pkg::*;

    localparam int PTR_W = (ARFC_QUEUE_DEPTH > 1) ? $clog2(ARFC_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ARFC_QUEUE_DEPTH + 1);

    plan_t            mem [ARFC_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CNT_W'(ARFC_QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ARFC_QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: sv/arfc_back.sv
// Back end: expands one queued plan into draw commands, one per cycle unless
// the output stalls, through a registered output stage. Depends on arfc_pkg.
module arfc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_not_empty,
    input  arfc_pkg::plan_t       q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output arfc_pkg::cmd_t        m_cmd
);
    import arfc_pkg::*;

    plan_t                 cur_reg, cur_next;
    logic [ARFC_SLOTS-1:0] remain_reg, remain_next;
    logic                  m_valid_reg, m_valid_next;
    cmd_t                  cmd_reg, cmd_next;

    logic [ARFC_SLOTS-1:0] pick_oh;
    logic                  cur_valid, out_ready, emit, last;
    logic                  p0, p1, p2, s0, s1, s2;
    logic [7:0]            alpha;
    logic [8:0]            w9;
    logic [16:0]           prod;
    logic [7:0]            mid_cov;

    always_comb begin
        cur_valid = (remain_reg != '0);
        pick_oh   = remain_reg & (~remain_reg + ARFC_SLOTS'(1));
        last      = ((remain_reg & ~pick_oh) == '0);
        out_ready = !m_valid_reg || m_ready;
        emit      = cur_valid && out_ready;
        q_pop     = q_not_empty && (!cur_valid || (emit && last));

        p0 = |pick_oh[2:0];
        p1 = |pick_oh[5:3];
        p2 = |pick_oh[8:6];
        s0 = pick_oh[0] | pick_oh[3] | pick_oh[6];
        s1 = pick_oh[1] | pick_oh[4] | pick_oh[7];
        s2 = pick_oh[2] | pick_oh[5] | pick_oh[8];

        // Row edge pixels scale the row alpha by the covered width.
        alpha = p0 ? cur_reg.alpha_top : cur_reg.alpha_bot;
        if (s0) begin
            w9 = cur_reg.single_col ? cur_reg.wcol : COV_ONE - {1'b0, cur_reg.frac_l};
        end else begin
            w9 = {1'b0, cur_reg.frac_r};
        end
        prod = 17'(alpha) * 17'(w9);

        if (s0) begin
            mid_cov = cur_reg.single_col ? 8'(cur_reg.wcol - 9'd1)
                                         : 8'(COV_ONE - {1'b0, cur_reg.frac_l});
        end else if (s1) begin
            mid_cov = COV_FULL;
        end else begin
            mid_cov = cur_reg.frac_r;
        end

        cmd_next.kind = s1 ? (p1 ? KIND_RECT : KIND_RUN) : KIND_COLUMN;
        cmd_next.x    = s0 ? cur_reg.x_left : (s1 ? cur_reg.x_left1 : cur_reg.x_right);
        cmd_next.y    = p0 ? cur_reg.y_top : (p1 ? cur_reg.y_mid : cur_reg.y_bot);
        cmd_next.w    = s1 ? cur_reg.run_w : 16'd1;
        cmd_next.h    = p1 ? cur_reg.height : 16'd1;
        cmd_next.cov  = p1 ? mid_cov : (s1 ? alpha : prod[15:8]);
        cmd_next.last = last;

        // Load a plan when idle or as the current one retires; else retire a slot.
        cur_next    = q_pop ? q_head : cur_reg;
        remain_next = remain_reg;
        if (q_pop) begin
            remain_next = q_head.mask;
        end else if (emit) begin
            remain_next = remain_reg & ~pick_oh;
        end

        m_valid_next = out_ready ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            cmd_reg <= cmd_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_cmd   = cmd_reg;

`ifndef SYNTHESIS
    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid |-> $onehot(pick_oh)) else $error("slot pick not one-hot");
    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> remain_reg != '0) else $error("loaded plan without commands");
    a_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last && !q_pop) |=> !cur_valid) else $error("plan not retired");
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg) else $error("emitted command not presented");
`endif

endmodule

// File: sv/antialiased_rect_fill_coverage_unit.sv
// Top level of the antialiased rectangle coverage fill.
// Instantiates arfc_front, arfc_queue and arfc_back; depends on arfc_pkg.
//
// Usage:
//   Slave channel (s_*): one rectangle request per handshake, edges in 16.8
//   fixed point by default (COORD_INT_BITS integer bits), fill flag in s_tuser.
//   Master channel (m_*): zero to nine draw commands per request, in order:
//   partial top row, middle band, partial bottom row. m_tlast marks the last
//   command of a request; m_tuser carries the command kind.
//   On an idle path a request passes through the plan queue, the back end's
//   plan register and the output register before its first command shows.
//   Throughput: one command per cycle unless the receiver stalls, limited
//   by the single output port. Requests producing no command are dropped
//   at the front. A two-entry plan queue lets the front accept new requests
//   while the back end works or while the receiver stalls; s_tready drops
//   only when the queue is full. A stalled command holds in the output
//   register. Reset (aresetn low, synchronous) empties the queue and
//   output stage.
module antialiased_rect_fill_coverage_unit #(
    parameter int COORD_INT_BITS = arfc_pkg::ARFC_COORD_INT_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // left_edge, top_edge, right_edge, bottom_edge (COORD_INT_BITS+8 each), zero pad
    input  logic [((4*(COORD_INT_BITS+8)+7)/8)*8-1:0] s_tdata,
    // fill_interior
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // pixel_x[15:0], pixel_y[31:16], span_width[47:32], span_height[63:48], coverage[71:64]
    output logic [71:0] m_tdata,
    // command_kind
    output logic [1:0] m_tuser,
    output logic m_tlast
);
    import arfc_pkg::*;

    localparam int EDGE_BITS = COORD_INT_BITS + 8;

    plan_t front_plan, q_head;
    cmd_t  cmd;
    logic  push, q_full, q_not_empty, q_pop;

    // Classify the request; empty rectangles never reach the queue.
    arfc_front #(
        .COORD_INT_BITS(COORD_INT_BITS)
    ) u_front (
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .left_edge    ($signed(s_tdata[EDGE_BITS-1:0])),
        .top_edge     ($signed(s_tdata[2*EDGE_BITS-1:EDGE_BITS])),
        .right_edge   ($signed(s_tdata[3*EDGE_BITS-1:2*EDGE_BITS])),
        .bottom_edge  ($signed(s_tdata[4*EDGE_BITS-1:3*EDGE_BITS])),
        .fill_interior(s_tuser[0]),
        .q_full       (q_full),
        .push         (push),
        .plan         (front_plan)
    );

    // Hold classified plans until the back end takes them.
    arfc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(front_plan),
        .pop      (q_pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    // Expand one plan per run of commands.
    arfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_cmd      (cmd)
    );

    assign m_tdata = {cmd.cov, cmd.h, cmd.w, cmd.y, cmd.x};
    assign m_tuser = cmd.kind;
    assign m_tlast = cmd.last;

endmodule

// File: verif/antialiased_rect_fill_coverage_unit_tb.sv
// Self-checking testbench for antialiased_rect_fill_coverage_unit.
// Holds its own command-expansion predictor and checks every draw command;
// depends on arfc_pkg and the RTL of the unit only.
module antialiased_rect_fill_coverage_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arfc_pkg::*;

    localparam int     COORD_BITS   = ARFC_COORD_INT_BITS;
    localparam int     EDGE_W       = COORD_BITS + 8;
    localparam int     DATA_W       = ((4 * EDGE_W + 7) / 8) * 8;
    localparam longint EDGE_MAX     = (longint'(1) <<< (EDGE_W - 1)) - 1;
    localparam longint EDGE_MIN     = -(longint'(1) <<< (EDGE_W - 1));
    localparam int     RESET_CYCLES = 6;
    localparam int     RANDOM_RECTS = 53;    // per idling phase
    localparam int     HOLD_AFTER   = 40;    // requests accepted before the long stall
    localparam int     HOLD_CYCLES  = 400;
    localparam int     STALL_LIMIT  = 3000;  // cycles with no handshake on either side
    localparam int     DRAIN_CYCLES = 20;

    typedef struct {
        logic signed [EDGE_W-1:0] l;
        logic signed [EDGE_W-1:0] t;
        logic signed [EDGE_W-1:0] r;
        logic signed [EDGE_W-1:0] b;
        logic                     fill;
    } rect_req_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [0:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [71:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    rect_req_t pending_rects[$];   // requests still to be offered
    cmd_t      expected_cmds[$];   // predicted draw commands, oldest first
    int        accepted_rects = 0;
    int        fail_count     = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct  = 11;
    int        recv_idle_pct  = 49;
    int        hold_left      = 0;
    bit        hold_done      = 1'b0;

    antialiased_rect_fill_coverage_unit #(
        .COORD_INT_BITS(COORD_BITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // left_edge, top_edge, right_edge, bottom_edge, zero pad
        .s_tuser (s_tuser),   // fill_interior
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // pixel_x, pixel_y, span_width, span_height, coverage
        .m_tuser (m_tuser),   // command_kind
        .m_tlast (m_tlast)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: expand one rectangle into its draw commands.
    // ------------------------------------------------------------------
    function automatic longint frac_px(longint v);
        return v & 255;
    endfunction

    function automatic void add_cmd(kind_t k, longint x, longint y, longint w, longint h,
                                    longint cov);
        cmd_t c;
        c.kind = k;
        c.x    = x[15:0];
        c.y    = y[15:0];
        c.w    = w[15:0];
        c.h    = h[15:0];
        c.cov  = cov[7:0];
        c.last = 1'b0;
        expected_cmds.push_back(c);
    endfunction

    // One pixel row: partial left pixel, full run, partial right pixel, each edge
    // pixel scaled by its covered width in 1/256 pixel.
    function automatic void add_row(longint l, longint y, longint r, longint alpha);
        longint lx;
        longint rx;
        lx = l >>> 8;
        if (lx == ((r - 1) >>> 8)) begin
            add_cmd(KIND_COLUMN, lx, y, 1, 1, (alpha * (r - l)) >>> 8);
            return;
        end
        if (frac_px(l) != 0) begin
            add_cmd(KIND_COLUMN, lx, y, 1, 1, (alpha * (256 - frac_px(l))) >>> 8);
            lx++;
        end
        rx = r >>> 8;
        if (rx > lx)
            add_cmd(KIND_RUN, lx, y, rx - lx, 1, alpha);
        if (frac_px(r) != 0)
            add_cmd(KIND_COLUMN, rx, y, 1, 1, (alpha * frac_px(r)) >>> 8);
    endfunction

    function automatic void expand_rect(longint l, longint t, longint r, longint b, bit fill);
        int     before_cnt;
        longint top_px;
        longint bot_px;
        longint ht;
        longint lx;
        longint rx;
        cmd_t   tail;
        before_cnt = expected_cmds.size();
        if (l >= r || t >= b)
            return;
        top_px = t >>> 8;
        if (top_px == ((b - 1) >>> 8)) begin
            // top and bottom edges share one pixel row
            add_row(l, top_px, r, b - t - 1);
        end else begin
            if (frac_px(t) != 0) begin
                add_row(l, top_px, r, 256 - frac_px(t));
                top_px++;
            end
            bot_px = b >>> 8;
            ht     = bot_px - top_px;
            if (ht > 0) begin
                lx = l >>> 8;
                if (lx == ((r - 1) >>> 8)) begin
                    // middle band fits in one pixel column
                    add_cmd(KIND_COLUMN, lx, top_px, 1, ht, r - l - 1);
                end else begin
                    if (frac_px(l) != 0) begin
                        add_cmd(KIND_COLUMN, lx, top_px, 1, ht, 256 - frac_px(l));
                        lx++;
                    end
                    rx = r >>> 8;
                    if (rx > lx && fill)
                        add_cmd(KIND_RECT, lx, top_px, rx - lx, ht, COV_FULL);
                    if (frac_px(r) != 0)
                        add_cmd(KIND_COLUMN, rx, top_px, 1, ht, frac_px(r));
                end
            end
            if (frac_px(b) != 0)
                add_row(l, bot_px, r, frac_px(b));
        end
        // flag the final command of this request
        if (expected_cmds.size() > before_cnt) begin
            tail      = expected_cmds.pop_back();
            tail.last = 1'b1;
            expected_cmds.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_rect(longint l, longint t, longint r, longint b, bit fill);
        rect_req_t q;
        q.l    = l[EDGE_W-1:0];
        q.t    = t[EDGE_W-1:0];
        q.r    = r[EDGE_W-1:0];
        q.b    = b[EDGE_W-1:0];
        q.fill = fill;
        pending_rects.push_back(q);
    endfunction

    // Pick one axis of a rectangle: mostly small extents, some empty, some
    // pixel-aligned, a few spanning most of the coordinate range.
    function automatic void pick_span(output longint lo, output longint hi);
        logic signed [EDGE_W-1:0] start;
        longint                   ext;
        start = EDGE_W'($urandom);
        if ($urandom_range(3) == 0)
            start[7:0] = '0;
        case ($urandom_range(9))
            0:       ext = 0;
            1, 2:    ext = $urandom_range(1, 255);
            3, 4, 5: ext = $urandom_range(256, 1023);
            6, 7:    ext = $urandom_range(1024, 8191);
            8:       ext = $urandom_range(8192, 1 << 20);
            default: ext = $urandom_range(1, (1 << EDGE_W) - 1);
        endcase
        if ($urandom_range(3) == 0)
            ext = ext & ~longint'(255);
        lo = start;
        hi = lo + ext;
        if (hi > EDGE_MAX) begin
            hi = EDGE_MAX;
            lo = hi - ext;
        end
    endfunction

    function automatic void queue_random_rects(int count);
        longint l;
        longint t;
        longint r;
        longint b;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15) begin
                // noise: raw edges, about three in four empty or inverted
                queue_rect($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
            end else begin
                pick_span(l, r);
                pick_span(t, b);
                queue_rect(l, t, r, b, $urandom_range(1));
            end
        end
    endfunction

    task automatic wait_sent();
        while (pending_rects.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued requests, predict each one on acceptance.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        rect_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expand_rect($signed(s_tdata[0*EDGE_W +: EDGE_W]),
                            $signed(s_tdata[1*EDGE_W +: EDGE_W]),
                            $signed(s_tdata[2*EDGE_W +: EDGE_W]),
                            $signed(s_tdata[3*EDGE_W +: EDGE_W]),
                            s_tuser[0]);
                accepted_rects <= accepted_rects + 1;
            end
            // load the next request only once the current one has gone
            if (!s_tvalid || s_tready) begin
                if (pending_rects.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_rects.pop_front();
                    s_tdata  <= DATA_W'({nxt.b, nxt.r, nxt.t, nxt.l});
                    s_tuser  <= nxt.fill;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each draw command against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : collect_commands
        cmd_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected command: kind %0d x %0d y %0d",
                           m_tuser, m_tdata[15:0], m_tdata[31:16]);
                    fail_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("command_kind",  want.kind, m_tuser);
                    check_field("pixel_x",       want.x,    m_tdata[15:0]);
                    check_field("pixel_y",       want.y,    m_tdata[31:16]);
                    check_field("span_width",    want.w,    m_tdata[47:32]);
                    check_field("span_height",   want.h,    m_tdata[63:48]);
                    check_field("coverage",      want.cov,  m_tdata[71:64]);
                    check_field("final_command", want.last, m_tlast);
                end
            end
            // hold off once for a long stretch so the plan queue fills and
            // the input side has to stall
            if (!hold_done && accepted_rects >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("antialiased_rect_fill_coverage_unit_tb failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed requests, then three random idling phases.
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty: zero width, zero height, inverted
        queue_rect('h1000, 'h1000, 'h1000, 'h2000, 1);
        queue_rect('h1000, 'h2040, 'h3000, 'h2040, 1);
        queue_rect('h3000, 'h1000, 'h1000, 'h3000, 0);
        // one row high: single pixel, split row, zero alpha, adjacent partial pixels
        queue_rect('h1020, 'h2010, 'h1080, 'h20F0, 1);
        queue_rect('h1040, 'h2010, 'h1840, 'h20F0, 0);
        queue_rect('h1000, 'h2010, 'h1800, 'h2011, 1);
        queue_rect('h1180, 'h2000, 'h1280, 'h2100, 1);
        queue_rect('h1001, 'h2001, 'h10FF, 'h20FF, 1);
        // middle band in one pixel column, fractional and exactly one pixel
        queue_rect('h1020, 'h2040, 'h10E0, 'h2840, 1);
        queue_rect('h1000, 'h2000, 'h1100, 'h2800, 1);
        // every edge fractional: all nine commands, then without the interior
        queue_rect('h1040, 'h2040, 'h1840, 'h2840, 1);
        queue_rect('h1040, 'h2040, 'h1840, 'h2840, 0);
        // pixel aligned: interior only, then nothing at all
        queue_rect('h1000, 'h2000, 'h1800, 'h2800, 1);
        queue_rect('h1000, 'h2000, 'h1800, 'h2800, 0);
        // aligned top, partial bottom row only
        queue_rect('h1000, 'h2000, 'h1800, 'h28C0, 0);
        // middle band with no interior between the left and right edge columns
        queue_rect('h1080, 'h2080, 'h1180, 'h2480, 1);
        // frac 255 on the near edges, frac 1 on the far edges
        queue_rect('h10FF, 'h20FF, 'h1301, 'h2401, 1);
        // negative coordinates
        queue_rect(-'h5A0, -'h3C1, -'h101, -'h2, 1);
        // coordinate extremes
        queue_rect(EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX, 1);
        queue_rect(EDGE_MIN, EDGE_MIN, EDGE_MIN + 1, EDGE_MIN + 1, 0);
        queue_rect(EDGE_MAX - 1, EDGE_MAX - 1, EDGE_MAX, EDGE_MAX, 1);

        // sender idles rarely, receiver idles half the time
        queue_random_rects(RANDOM_RECTS);
        wait_sent();

        // swap: sender idles half the time, receiver rarely
        send_idle_pct = 49;
        recv_idle_pct = 11;
        queue_random_rects(RANDOM_RECTS);
        wait_sent();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_rects(RANDOM_RECTS);
        wait_sent();

        // drain, then give the block time to show any stray command
        while (expected_cmds.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("antialiased_rect_fill_coverage_unit_tb passed");
        end else begin
            $display("antialiased_rect_fill_coverage_unit_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/arfc_pkg.sv
sv/arfc_front.sv
sv/arfc_queue.sv
sv/arfc_back.sv
sv/antialiased_rect_fill_coverage_unit.sv
verif/antialiased_rect_fill_coverage_unit_tb.sv
